>>> sv/adctemp_pkg.sv
// Shared constants, calibration table and control types of the ADC-to-temperature block.
`timescale 1ns / 1ps
`default_nettype none

package adctemp_pkg;

    // Field widths of the request and result channels.
    localparam int ADC_W      = 10;
    localparam int TEMP_OUT_W = 12;
    localparam int WHOLE_W    = 7;
    localparam int TENTHS_W   = 4;

    // Calibration table shape and fixed-point format.
    localparam int TABLE_POINTS  = 13;
    localparam int FRACTION_BITS = 5;
    localparam int IDX_W         = $clog2(TABLE_POINTS);

    // Point i stands for FIRST_DEG + STEP_DEG * i degrees.
    localparam int FIRST_DEG    = -20;
    localparam int STEP_DEG     = 5;
    localparam int STEP_SCALED  = STEP_DEG * (1 << FRACTION_BITS);
    localparam int FIRST_SCALED = FIRST_DEG * (1 << FRACTION_BITS);
    localparam int LAST_SCALED  = FIRST_SCALED + STEP_SCALED * (TABLE_POINTS - 1);
    localparam int BASE_SCALED  = FIRST_SCALED - STEP_SCALED;

    // Divider sizing: the dividend is STEP_SCALED times the offset into the interval.
    localparam int STEP_W = $clog2(STEP_SCALED + 1);
    localparam int NUM_W  = STEP_W + ADC_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    // Internal signed width for the interpolated temperature.
    localparam int TEMP_W = TEMP_OUT_W + 2;

    // Tenths digit is the fraction times ten, so four extra bits hold the product.
    localparam int TENTHS_PROD_W = FRACTION_BITS + TENTHS_W;

    // Ascending converter readings of the calibration points.
    localparam logic [ADC_W-1:0] CAL_ROM [TABLE_POINTS] = '{
        10'd75,  10'd100, 10'd131, 10'd169, 10'd214, 10'd265, 10'd322,
        10'd384, 10'd447, 10'd512, 10'd574, 10'd633, 10'd687
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clamped;
        logic scan_hit;
        logic div_done;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

>>> sv/adctemp_ctrl.sv
// Sequencing state machine of the ADC-to-temperature block.
`timescale 1ns / 1ps
`default_nettype none

module adctemp_ctrl
    import adctemp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_sample = 1'b1;
                    n_state           = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.clamped) begin
                    n_state = S_DONE;
                end else if (i_status.scan_hit) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted request always starts a table scan.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_status.out_busy)
        else $error("result register loaded while occupied");

    // The divider is never stepped past its last quotient bit.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_step |-> !i_status.div_done)
        else $error("divider stepped after completion");

endmodule

`default_nettype wire

>>> sv/adctemp_dp.sv
// Datapath: table scan, interval multiply, serial divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module adctemp_dp
    import adctemp_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire        [ADC_W-1:0]       i_adc_sample,
    input  wire                          i_ready,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    output logic                         o_valid,
    output logic signed [TEMP_OUT_W-1:0] o_temp_scaled,
    output logic signed [WHOLE_W-1:0]    o_whole_degrees,
    output logic        [TENTHS_W-1:0]   o_tenths_digit,
    output logic                         o_out_of_range
);

    logic [ADC_W-1:0] r_sample;
    logic [IDX_W-1:0] r_idx;
    logic [ADC_W-1:0] r_den;
    logic [ADC_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;

    logic                     v_below;
    logic                     v_under;
    logic                     v_above;
    logic [ADC_W-1:0]         v_lo;
    logic [ADC_W-1:0]         v_hi;
    logic [ADC_W-1:0]         v_diff;
    logic [ADC_W-1:0]         v_den;
    logic [NUM_W-1:0]         v_prod;
    logic [ADC_W:0]           v_shift;
    logic [ADC_W:0]           v_trial;
    logic signed [TEMP_W-1:0] v_temp;
    logic signed [TEMP_W-1:0] v_whole;
    logic [TENTHS_PROD_W-1:0] v_tenths;

    // Range checks against the ends of the table.
    assign v_below = (r_sample <= CAL_ROM[0]);
    assign v_under = (r_sample <  CAL_ROM[0]);
    assign v_above = (r_sample >  CAL_ROM[TABLE_POINTS-1]);

    // Interval bounds at the current scan index.
    assign v_hi   = CAL_ROM[r_idx];
    assign v_lo   = CAL_ROM[r_idx - IDX_W'(1)];
    assign v_diff = r_sample - v_lo;
    assign v_den  = (v_hi > v_lo) ? (v_hi - v_lo) : ADC_W'(1);
    assign v_prod = NUM_W'(STEP_SCALED) * NUM_W'(v_diff);

    // One restoring division step: shift in a dividend bit, try the subtraction.
    assign v_shift = {r_rem, r_dvd[NUM_W-1]};
    assign v_trial = v_shift - {1'b0, r_den};

    // Status back to the controller.
    assign o_status.clamped  = v_below || v_above;
    assign o_status.scan_hit = (r_idx == IDX_W'(TABLE_POINTS - 1)) || (r_sample <= v_hi);
    assign o_status.div_done = (r_cnt == CNT_W'(NUM_W));
    assign o_status.out_busy = r_out_valid && !i_ready;

    // Final temperature: clamp values or the interval base plus the quotient.
    always_comb begin
        if (v_below) begin
            v_temp = TEMP_W'(FIRST_SCALED);
        end else if (v_above) begin
            v_temp = TEMP_W'(LAST_SCALED);
        end else begin
            v_temp = TEMP_W'(BASE_SCALED + STEP_SCALED * int'(r_idx))
                   + TEMP_W'(r_dvd[STEP_W-1:0]);
        end
        v_whole  = v_temp >>> FRACTION_BITS;
        v_tenths = TENTHS_PROD_W'(v_temp[FRACTION_BITS-1:0]) * TENTHS_PROD_W'(10);
    end

    // Sample capture and table scan index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_adc_sample;
            r_idx    <= IDX_W'(1);
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Serial divider: the product is loaded once, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd <= v_prod;
            r_rem <= '0;
            r_den <= v_den;
        end else if (i_cmd.div_step) begin
            if (!v_trial[ADC_W]) begin
                r_rem <= v_trial[ADC_W-1:0];
                r_dvd <= {r_dvd[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= v_shift[ADC_W-1:0];
                r_dvd <= {r_dvd[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Result register; it stays until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_temp_scaled   <= v_temp[TEMP_OUT_W-1:0];
            o_whole_degrees <= v_whole[WHOLE_W-1:0];
            o_tenths_digit  <= v_tenths[TENTHS_PROD_W-1:FRACTION_BITS];
            o_out_of_range  <= v_under || v_above;
        end
    end

    assign o_valid = r_out_valid;

    // Inside an interval the quotient never exceeds one full step.
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.div_done && !o_status.clamped) |-> (r_dvd <= NUM_W'(STEP_SCALED)))
        else $error("interpolation quotient exceeds one table step");

    // The remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // A loaded result is presented in the following cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> o_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> sv/adc_to_temperature_interpolator.sv
// Top level of the ADC-to-temperature piecewise linear interpolator.
//
// One request carries a 10-bit converter reading on i_adc_sample, taken when i_valid
// and o_ready are both high. One result follows for each request: the temperature
// times 32 (o_temp_scaled), its floor whole degrees, a tenths digit and a flag for
// readings strictly outside the calibration table, whose result is clamped to the
// end temperature. Results are offered on o_valid and taken when i_ready is high.
// The block works on one request at a time. A reading at or below the first point or
// above the last ends the scan at once and goes straight to the final step. Otherwise
// the scan walks the table one point a cycle up to the interval found at index k, then
// a shift-and-subtract divider produces one quotient bit a cycle, and the result is
// loaded. o_ready returns the cycle after the result is loaded.
// The result register holds its value while i_ready is low; a new request is then
// still taken and computed, and waits in the final step until the register is free.
// Synchronous reset clears the sequencer and the result valid flag; the block is
// ready for a request in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module adc_to_temperature_interpolator
    import adctemp_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire        [ADC_W-1:0]       i_adc_sample,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [TEMP_OUT_W-1:0] o_temp_scaled,
    output logic signed [WHOLE_W-1:0]    o_whole_degrees,
    output logic        [TENTHS_W-1:0]   o_tenths_digit,
    output logic                         o_out_of_range
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    adctemp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath with the result register.
    adctemp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adc_sample    (i_adc_sample),
        .i_ready         (i_ready),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_valid         (o_valid),
        .o_temp_scaled   (o_temp_scaled),
        .o_whole_degrees (o_whole_degrees),
        .o_tenths_digit  (o_tenths_digit),
        .o_out_of_range  (o_out_of_range)
    );

endmodule

`default_nettype wire

>>> sim/adc_to_temperature_interpolator_tb.sv
// Self-checking testbench for the ADC-to-temperature interpolator.
`timescale 1ns / 1ps

module adc_to_temperature_interpolator_tb
    import adctemp_pkg::*;
();

    // Independent description of the calibration and the fixed-point format.
    localparam int POINT_COUNT   = 13;
    localparam int FRAC_BITS     = 5;
    localparam int LOW_END_DEG   = -20;
    localparam int DEG_PER_POINT = 5;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int REPORT_LIMIT  = 10;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_style;

    // One expected result, with the sample that caused it for reporting.
    typedef struct packed {
        logic [ADC_W-1:0]             sample;
        logic signed [TEMP_OUT_W-1:0] temp_scaled;
        logic signed [WHOLE_W-1:0]    whole_degrees;
        logic [TENTHS_W-1:0]          tenths_digit;
        logic                         out_of_range;
    } t_temp_reading;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [ADC_W-1:0]             i_adc_sample;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [TEMP_OUT_W-1:0] o_temp_scaled;
    logic signed [WHOLE_W-1:0]    o_whole_degrees;
    logic [TENTHS_W-1:0]          o_tenths_digit;
    logic                         o_out_of_range;

    t_temp_reading expected_readings[$];
    t_temp_reading oldest_reading;
    t_stall_style  stall_style;
    int            stall_phase;
    int            hold_off_left;
    int            cycle_count;
    int            samples_sent;
    int            clamped_sent;
    int            readings_checked;
    int            failure_count;

    adc_to_temperature_interpolator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_adc_sample    (i_adc_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_temp_scaled   (o_temp_scaled),
        .o_whole_degrees (o_whole_degrees),
        .o_tenths_digit  (o_tenths_digit),
        .o_out_of_range  (o_out_of_range)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Converter reading of each calibration point, in ascending order.
    function automatic int point_adc(input int idx);
        case (idx)
            0:       return 75;
            1:       return 100;
            2:       return 131;
            3:       return 169;
            4:       return 214;
            5:       return 265;
            6:       return 322;
            7:       return 384;
            8:       return 447;
            9:       return 512;
            10:      return 574;
            11:      return 633;
            default: return 687;
        endcase
    endfunction

    // Expected reading for one sample: clamp at the ends, otherwise interpolate
    // inside the first interval whose upper point is not below the sample.
    function automatic t_temp_reading predict_reading(input logic [ADC_W-1:0] sample);
        t_temp_reading reading;
        int            s;
        int            temp;
        int            idx;
        int            lo;
        int            hi;
        int            whole;
        int            frac;
        s = int'(sample);
        reading.sample = sample;
        reading.out_of_range = 1'b0;
        if (s <= point_adc(0)) begin
            temp = LOW_END_DEG * (1 << FRAC_BITS);
            reading.out_of_range = (s < point_adc(0));
        end else if (s > point_adc(POINT_COUNT - 1)) begin
            temp = (LOW_END_DEG + DEG_PER_POINT * (POINT_COUNT - 1)) * (1 << FRAC_BITS);
            reading.out_of_range = 1'b1;
        end else begin
            idx = 1;
            while (idx < POINT_COUNT - 1 && s > point_adc(idx))
                idx++;
            lo = point_adc(idx - 1);
            hi = point_adc(idx);
            temp = (LOW_END_DEG + DEG_PER_POINT * (idx - 1)) * (1 << FRAC_BITS)
                 + (DEG_PER_POINT * (1 << FRAC_BITS) * (s - lo)) / ((hi > lo) ? hi - lo : 1);
        end
        // Floor division and the non-negative fraction bits.
        whole = temp >>> FRAC_BITS;
        frac  = temp & ((1 << FRAC_BITS) - 1);
        reading.temp_scaled   = TEMP_OUT_W'(temp);
        reading.whole_degrees = WHOLE_W'(whole);
        reading.tenths_digit  = TENTHS_W'((frac * 10) >> FRAC_BITS);
        return reading;
    endfunction

    // Mostly samples inside the table, some hugging a point, some anywhere.
    function automatic logic [ADC_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return ADC_W'($urandom_range(point_adc(0), point_adc(POINT_COUNT - 1)));
        else if (roll < 90)
            return ADC_W'(point_adc($urandom_range(0, POINT_COUNT - 1))
                          + $urandom_range(0, 2) - 1);
        else
            return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
    endfunction

    // Offers one request and waits until it is taken; valid stays high afterwards.
    task automatic send_sample(input logic [ADC_W-1:0] sample);
        t_temp_reading reading;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_adc_sample <= sample;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        reading = predict_reading(sample);
        expected_readings.push_back(reading);
        samples_sent++;
        if (reading.out_of_range)
            clamped_sent++;
    endtask

    // Drops valid for the given number of cycles.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid      <= 1'b0;
            i_adc_sample <= ADC_W'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Random requests in bursts of random length separated by random gaps.
    task automatic send_stream(input int count, input int max_burst, input int max_gap);
        int burst_left;
        burst_left = $urandom_range(1, max_burst);
        for (int n = 0; n < count; n++) begin
            send_sample(pick_sample());
            burst_left--;
            if (burst_left == 0) begin
                pause_sender($urandom_range(0, max_gap));
                burst_left = $urandom_range(1, max_burst);
            end
        end
        pause_sender(1);
    endtask

    task automatic wait_for_readings();
        while (expected_readings.size() != 0)
            @(posedge i_clk);
    endtask

    // Every point, neighbours of the first, one past the last, all-zero, all-one.
    task automatic test_directed_points();
        stall_style = STALL_NONE;
        send_sample(ADC_W'(0));
        send_sample(ADC_W'(point_adc(0) - 1));
        send_sample(ADC_W'(point_adc(0)));
        send_sample(ADC_W'(point_adc(0) + 1));
        for (int idx = 1; idx < POINT_COUNT; idx++) begin
            send_sample(ADC_W'(point_adc(idx)));
            pause_sender(idx % 3);
        end
        send_sample(ADC_W'(point_adc(POINT_COUNT - 1) + 1));
        send_sample(ADC_W'((1 << ADC_W) - 1));
        send_sample(ADC_W'(point_adc(4) - 1));
        send_sample(ADC_W'(300));
        pause_sender(1);
        wait_for_readings();
    endtask

    // Long bursts with the receiver always ready.
    task automatic test_streaming_random();
        stall_style = STALL_NONE;
        send_stream(800, 40, 3);
    endtask

    // Short bursts and wide gaps against a randomly stalling receiver.
    task automatic test_random_stalls();
        stall_style = STALL_RANDOM;
        send_stream(900, 8, 20);
    endtask

    // Fixed receiver stall pattern, so gaps land on every phase of the work.
    task automatic test_pattern_stalls();
        stall_style = STALL_PATTERN;
        send_stream(250, 5, 7);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        wait_for_readings();
        stall_style   = STALL_NONE;
        hold_off_left = HOLD_OFF_LEN;
        for (int n = 0; n < 24; n++)
            send_sample(pick_sample());
        pause_sender(1);
    endtask

    // Receiver: a long hold-off when asked for, otherwise the current stall style.
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_ready <= 1'b0;
            hold_off_left--;
        end else begin
            case (stall_style)
                STALL_NONE: begin
                    i_ready <= 1'b1;
                end
                STALL_RANDOM: begin
                    i_ready <= ($urandom_range(0, 99) >= 35);
                end
                default: begin
                    i_ready <= ((stall_phase % 7) >= 3);
                    stall_phase++;
                end
            endcase
        end
    end

    // Compare each result taken with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_readings.size() == 0) begin
                failure_count++;
                if (failure_count <= REPORT_LIMIT)
                    $display("Unexpected result: temp %0d whole %0d tenths %0d range %0b",
                             o_temp_scaled, o_whole_degrees, o_tenths_digit,
                             o_out_of_range);
            end else begin
                oldest_reading = expected_readings.pop_front();
                readings_checked++;
                if (o_temp_scaled !== oldest_reading.temp_scaled
                        || o_whole_degrees !== oldest_reading.whole_degrees
                        || o_tenths_digit !== oldest_reading.tenths_digit
                        || o_out_of_range !== oldest_reading.out_of_range) begin
                    failure_count++;
                    if (failure_count <= REPORT_LIMIT) begin
                        $display("Mismatch for sample %0d: expected temp %0d whole %0d %s",
                                 oldest_reading.sample, oldest_reading.temp_scaled,
                                 oldest_reading.whole_degrees, "");
                        $display("    tenths %0d range %0b, got temp %0d whole %0d %s",
                                 oldest_reading.tenths_digit, oldest_reading.out_of_range,
                                 o_temp_scaled, o_whole_degrees, "");
                        $display("    tenths %0d range %0b",
                                 o_tenths_digit, o_out_of_range);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Reset, the test sequence and the final verdict.
    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_ready          = 1'b0;
        i_adc_sample     = '0;
        stall_style      = STALL_NONE;
        stall_phase      = 0;
        hold_off_left    = 0;
        cycle_count      = 0;
        samples_sent     = 0;
        clamped_sent     = 0;
        readings_checked = 0;
        failure_count    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_points();
        test_streaming_random();
        test_random_stalls();
        test_pattern_stalls();
        test_backpressure();

        wait_for_readings();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d samples, %0d clamped outside the table; checked %0d results.",
                 samples_sent, clamped_sent, readings_checked);
        $display("Receiver ran free, stalled at random, on a fixed pattern and held off %0d %s",
                 HOLD_OFF_LEN, "cycles once.");
        if (failure_count == 0 && expected_readings.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d failures", failure_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
